/* rtl/kct_pkg.sv */
// ----------------------------------------------------------------------------
// kct_pkg: shared definitions for the keyed counter table
// Table size, opcode and status codes, and the token that travels through
// the chain of table cells.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned CNT_W       = 64;
  localparam int unsigned EIDX_W      = 7;

  localparam logic [IDX_W-1:0]         LAST_SLOT = IDX_W'(MAX_ENTRIES - 1);
  localparam logic signed [EIDX_W-1:0] IDX_NONE  = -7'sd1;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_LOOKUP   = 2'd1,
    OP_ADD      = 2'd2,
    OP_REMOVE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // One transaction in flight through the cells.
  typedef struct packed {
    logic                      vld;
    op_e                       op;
    logic [KEY_W-1:0]          key;
    logic [CNT_W-1:0]          amount;
    logic                      full;   // table was full when the item entered
    logic                      hit;    // key found in a live slot
    logic                      claim;  // key appended to a free slot
    logic signed [EIDX_W-1:0]  idx;
    logic [CNT_W-1:0]          cnt;
  } tok_t;

  // Slot number masked to the width of the result field.
  function automatic logic signed [EIDX_W-1:0] to_eidx(input logic [IDX_W-1:0] slot);
    logic [IDX_W+EIDX_W-1:0] ext;
    ext = {{EIDX_W{1'b0}}, slot};
    return ext[EIDX_W-1:0];
  endfunction

endpackage

/* rtl/kct_in_if.sv */
// ----------------------------------------------------------------------------
// kct_in_if: request channel of the keyed counter table
// Valid/ready channel carrying opcode, key and amount.
// ----------------------------------------------------------------------------
interface kct_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [kct_pkg::KEY_W-1:0] key;
  logic [kct_pkg::CNT_W-1:0] amount;

  modport source (output valid, opcode, key, amount, input ready);
  modport sink   (input valid, opcode, key, amount, output ready);
endinterface

/* rtl/kct_out_if.sv */
// ----------------------------------------------------------------------------
// kct_out_if: response channel of the keyed counter table
// Valid/ready channel carrying status, found flag, slot and counter.
// ----------------------------------------------------------------------------
interface kct_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic                              found;
  logic signed [kct_pkg::EIDX_W-1:0] entry_index;
  logic [kct_pkg::CNT_W-1:0]         counter_value;

  modport source (output valid, status, found, entry_index, counter_value, input ready);
  modport sink   (input valid, status, found, entry_index, counter_value, output ready);
endinterface

/* rtl/kct_cell.sv */
// ----------------------------------------------------------------------------
// kct_cell: one slot of the keyed counter table
// Holds a key, its counter and a live flag. The token passing by is compared
// against the key, updates the counter on a match, or claims a free slot.
// ----------------------------------------------------------------------------
module kct_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [kct_pkg::IDX_W-1:0] cell_idx_i,
  input  kct_pkg::tok_t             tok_i,
  output kct_pkg::tok_t             tok_o,
  output logic                      live_o
);

  kct_pkg::tok_t             tok_d, tok_q;
  logic                      live_d, live_q;
  logic [kct_pkg::KEY_W-1:0] key_d, key_q;
  logic [kct_pkg::CNT_W-1:0] cnt_d, cnt_q;

  always_comb begin
    tok_d  = tok_i;
    live_d = live_q;
    key_d  = key_q;
    cnt_d  = cnt_q;
    if (tok_i.vld) begin
      if (live_q && !tok_i.hit && (key_q == tok_i.key)) begin
        case (tok_i.op)
          kct_pkg::OP_ADD:    cnt_d = cnt_q + tok_i.amount;
          kct_pkg::OP_REMOVE: cnt_d = (tok_i.amount < cnt_q) ? (cnt_q - tok_i.amount) : '0;
          default:            cnt_d = cnt_q;
        endcase
        tok_d.hit = 1'b1;
        tok_d.idx = kct_pkg::to_eidx(cell_idx_i);
        tok_d.cnt = cnt_d;
      end else if (!live_q && !tok_i.hit && !tok_i.claim && !tok_i.full &&
                   (tok_i.op == kct_pkg::OP_REGISTER)) begin
        // Live slots form a prefix, so the first free slot is the next one.
        live_d      = 1'b1;
        key_d       = tok_i.key;
        cnt_d       = '0;
        tok_d.claim = 1'b1;
        tok_d.idx   = kct_pkg::to_eidx(cell_idx_i);
        tok_d.cnt   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      live_q <= 1'b0;
    end else if (advance_i) begin
      tok_q  <= tok_d;
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      key_q <= key_d;
      cnt_q <= cnt_d;
    end
  end

  assign tok_o  = tok_q;
  assign live_o = live_q;

endmodule

/* rtl/keyed_counter_table_core.sv */
// ----------------------------------------------------------------------------
// keyed_counter_table_core: associative table of 64-bit keys and counters
// Top level: admits one transaction, passes it along the row of cells and
// presents the result in an output register.
// ----------------------------------------------------------------------------
// A request enters a row of MAX_ENTRIES cells and moves one cell per clock
// while the row is not held; each cell compares its slot, updates its counter
// or takes the new key as the request passes. The result is then registered
// in the output register. One request is in the table at a time: a new one
// is taken only once the last has been loaded into the output register. A
// stalled response holds the row. At most MAX_ENTRIES-1 slots are usable,
// since a register is refused once the entry count reaches MAX_ENTRIES-1.
module keyed_counter_table_core (
  input  logic clk_i,
  input  logic rst_ni,
  kct_in_if.sink    in_i,
  kct_out_if.source out_o
);

  kct_pkg::tok_t                      chain [kct_pkg::MAX_ENTRIES+1];
  logic [kct_pkg::MAX_ENTRIES-1:0]    live;
  logic [kct_pkg::MAX_ENTRIES-1:0]    tok_vld;
  logic                               advance;
  logic                               accept;
  logic                               load;
  logic                               busy_d, busy_q;
  logic [kct_pkg::IDX_W-1:0]          count_d, count_q;
  logic                               out_vld_d, out_vld_q;
  kct_pkg::status_e                   status_d, status_q;
  logic                               found_q;
  logic signed [kct_pkg::EIDX_W-1:0]  eidx_q;
  logic [kct_pkg::CNT_W-1:0]          cval_q;
  kct_pkg::tok_t                      last;

  assign last    = chain[kct_pkg::MAX_ENTRIES];
  assign advance = !(last.vld && out_vld_q && !out_o.ready);
  assign accept  = in_i.valid && in_i.ready;
  assign load    = last.vld && advance;
  assign in_i.ready = !busy_q;

  always_comb begin
    chain[0]        = '0;
    chain[0].vld    = accept;
    chain[0].op     = kct_pkg::op_e'(in_i.opcode);
    chain[0].key    = in_i.key;
    chain[0].amount = in_i.amount;
    chain[0].full   = (count_q >= kct_pkg::LAST_SLOT);
    chain[0].idx    = kct_pkg::IDX_NONE;
    chain[0].cnt    = '0;
  end

  for (genvar i = 0; i < kct_pkg::MAX_ENTRIES; i++) begin : g_cell
    kct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .cell_idx_i (kct_pkg::IDX_W'(i)),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1]),
      .live_o     (live[i])
    );
    assign tok_vld[i] = chain[i+1].vld;
  end

  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (load) begin
      busy_d = 1'b0;
    end
    if (load && last.claim) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    status_d = kct_pkg::ST_OK;
    if ((last.op == kct_pkg::OP_REGISTER) && last.full) begin
      status_d = kct_pkg::ST_FULL;
    end else if ((last.op == kct_pkg::OP_LOOKUP) && !last.hit) begin
      status_d = kct_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      found_q  <= last.hit;
      eidx_q   <= last.idx;
      cval_q   <= last.cnt;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = status_q;
  assign out_o.found         = found_q;
  assign out_o.entry_index   = eidx_q;
  assign out_o.counter_value = cval_q;

  // At most one transaction travels through the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_vld))
    else $error("more than one transaction in the cell row");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> (tok_vld == '0))
    else $error("transaction in the cell row while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !busy_q |-> ($countones(live) == int'(count_q)))
    else $error("live slots disagree with the entry count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= kct_pkg::LAST_SLOT)
    else $error("entry count beyond the usable slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   load |-> !(last.hit && last.claim))
    else $error("transaction both matched and appended a key");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for keyed_counter_table_core
// Random and directed opcode streams go into the table, and every response
// is checked against a predictor that keeps its own copy of the keys,
// counters and fill level. Both channels stall in random bursts. Halfway
// through, the table is filled to capacity and the run goes on with a full
// table.
// ----------------------------------------------------------------------------
module tb;
  import kct_pkg::*;

  typedef struct packed {
    status_e                  status;
    logic                     found;
    logic signed [EIDX_W-1:0] entry_index;
    logic [CNT_W-1:0]         counter_value;
  } response_t;

  // Mirrors the table contents and holds the responses still owed by the block.
  class kct_scoreboard;
    logic [KEY_W-1:0] slot_key [MAX_ENTRIES];
    logic [CNT_W-1:0] slot_cnt [MAX_ENTRIES];
    int unsigned      live;
    response_t        pending_results[$];
    int unsigned      errors;
    int unsigned      n_checked;
    int unsigned      n_full;
    int unsigned      n_miss;
    int unsigned      n_op[4];

    function new();
      live   = 0;
      errors = 0;
      foreach (slot_cnt[i]) begin
        slot_cnt[i] = '0;
        slot_key[i] = '0;
      end
    endfunction

    // Lowest live slot holding the key, or -1.
    function int slot_of(logic [KEY_W-1:0] key);
      for (int i = 0; i < int'(live); i++) begin
        if (slot_key[i] == key) return i;
      end
      return -1;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void apply_request(op_e op, logic [KEY_W-1:0] key, logic [CNT_W-1:0] amount);
      response_t r;
      int        slot;
      slot     = slot_of(key);
      r.found  = (slot >= 0);
      r.status = ST_OK;
      n_op[int'(op)]++;
      case (op)
        OP_REGISTER: begin
          // The capacity check wins even when the key is already present.
          if (live + 1 >= MAX_ENTRIES) begin
            r.status = ST_FULL;
          end else if (slot < 0) begin
            slot           = live;
            slot_key[live] = key;
            live++;
          end
        end
        OP_LOOKUP: begin
          if (slot < 0) r.status = ST_NOT_FOUND;
        end
        OP_ADD: begin
          if (slot >= 0) slot_cnt[slot] = slot_cnt[slot] + amount;
        end
        default: begin
          if (slot >= 0) slot_cnt[slot] = (amount < slot_cnt[slot]) ?
                                          slot_cnt[slot] - amount : '0;
        end
      endcase
      if (slot >= 0) begin
        r.entry_index   = EIDX_W'(slot);
        r.counter_value = slot_cnt[slot];
      end else begin
        r.entry_index   = IDX_NONE;
        r.counter_value = '0;
        n_miss++;
      end
      if (r.status == ST_FULL) n_full++;
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, logic found,
                                 logic signed [EIDX_W-1:0] entry_index,
                                 logic [CNT_W-1:0] counter_value);
      response_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected response: status %0d, counter_value %h", status, counter_value);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      n_checked++;
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (found !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, found);
        errors++;
      end
      if (entry_index !== e.entry_index) begin
        $error("entry_index: expected %0d, actual %0d", e.entry_index, entry_index);
        errors++;
      end
      if (counter_value !== e.counter_value) begin
        $error("counter_value: expected %h, actual %h", e.counter_value, counter_value);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kct_in_if  in_if ();
  kct_out_if out_if ();

  keyed_counter_table_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  kct_scoreboard sb = new();

  bit quiet;      // no stalls on either side
  bit tx_bursty;
  bit rx_bursty;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Handshakes are sampled mid-cycle, where valid and ready are settled for the
  // next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.apply_request(op_e'(in_if.opcode), in_if.key, in_if.amount);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_response(out_if.status, out_if.found, out_if.entry_index,
                          out_if.counter_value);
      end
    end
  end

  // Response side: ready drops in bursts while the bursty mode is on.
  initial begin
    int unsigned stall_left;
    int unsigned cycle;
    stall_left = 0;
    cycle      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle % 200 == 0) rx_bursty = ($urandom_range(0, 2) != 0);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && rx_bursty && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Called just after a rising edge; returns at the edge that accepts the item.
  task automatic send(op_e op, logic [KEY_W-1:0] key, logic [CNT_W-1:0] amount);
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.key    <= key;
    in_if.amount <= amount;
    @(negedge clk_i);
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle(int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!quiet && tx_bursty && $urandom_range(0, 3) == 0) idle($urandom_range(1, 8));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = {$urandom, $urandom}; while (sb.slot_of(k) >= 0);
    return k;
  endfunction

  // Mostly keys already in the table, some corner values and some random ones.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6 && sb.live > 0) return sb.slot_key[$urandom_range(0, sb.live - 1)];
    if (r == 6) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return '1;
        default: return 64'd1 << $urandom_range(0, 63);
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Amounts cluster around the current counter so that removes hit the floor
  // both exactly and by one.
  function automatic logic [CNT_W-1:0] pick_amount(logic [KEY_W-1:0] key);
    int               slot;
    logic [CNT_W-1:0] cur;
    slot = sb.slot_of(key);
    cur  = (slot >= 0) ? sb.slot_cnt[slot] : '0;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return cur;
      3:       return cur + 1;
      4:       return cur - 1;
      5:       return CNT_W'($urandom_range(0, 4096));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_items(int unsigned n);
    op_e              op;
    logic [KEY_W-1:0] key;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) tx_bursty = ($urandom_range(0, 2) != 0);
      op = op_e'($urandom_range(0, 3));
      if (op == OP_REGISTER && $urandom_range(0, 9) < 4) key = fresh_key();
      else key = pick_key();
      send(op, key, pick_amount(key));
      maybe_gap();
    end
  endtask

  initial begin
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_REGISTER;
    in_if.key    <= '0;
    in_if.amount <= '0;
    rst_ni       <= 1'b0;
    tx_bursty = 1'b1;
    rx_bursty = 1'b1;
    quiet     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: every key is unknown.
    send(OP_LOOKUP,   64'h0, 64'h0);
    send(OP_ADD,      '1, '1);
    send(OP_REMOVE,   64'h0123_4567_89ab_cdef, 64'h5);
    // New keys at the extremes, then a duplicate register.
    send(OP_REGISTER, 64'h0, '1);
    send(OP_REGISTER, '1, 64'h0);
    send(OP_REGISTER, 64'h0, 64'h0);
    // Counter wraparound, exact and excess removes.
    send(OP_ADD,      64'h0, '1);
    send(OP_ADD,      64'h0, 64'h2);
    send(OP_LOOKUP,   64'h0, 64'h0);
    send(OP_REMOVE,   64'h0, 64'h0);
    send(OP_REMOVE,   64'h0, 64'h1);
    send(OP_ADD,      '1, 64'h5);
    send(OP_REMOVE,   '1, 64'h6);
    send(OP_ADD,      '1, 64'h8000_0000_0000_0000);
    send(OP_REMOVE,   '1, '1);
    send(OP_LOOKUP,   '1, 64'h0);
    send(OP_LOOKUP,   64'h5555_5555_5555_5555, '1);
    send(OP_REGISTER, 64'haaaa_aaaa_aaaa_aaaa, 64'h0);
    send(OP_ADD,      64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa);
    send(OP_REMOVE,   64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    drain();

    random_items(450);
    drain();

    // Fill the table to its usable capacity, then try both kinds of register.
    while (sb.live + 1 < MAX_ENTRIES) begin
      send(OP_REGISTER, fresh_key(), {$urandom, $urandom});
      maybe_gap();
    end
    send(OP_REGISTER, sb.slot_key[0], 64'h0);
    send(OP_REGISTER, fresh_key(), 64'h0);
    send(OP_LOOKUP, sb.slot_key[LAST_SLOT - 1], 64'h0);

    random_items(350);
    quiet = 1'b1;
    random_items(150);

    drain();
    repeat (MAX_ENTRIES + 16) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d responses never arrived", sb.pending());
      sb.errors++;
    end
    $display("tb: %0d responses checked (%0d register, %0d lookup, %0d add, %0d remove)",
             sb.n_checked, sb.n_op[OP_REGISTER], sb.n_op[OP_LOOKUP], sb.n_op[OP_ADD],
             sb.n_op[OP_REMOVE]);
    $display("tb: table filled to %0d slots, %0d full refusals, %0d unknown-key results",
             sb.live, sb.n_full, sb.n_miss);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Ends a run that hangs and reports it as an error.
  initial begin
    #3200000;
    $display("tb: errors");
    $finish;
  end

endmodule
